>>> hdl/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg: shared types for the positional list store
// Request and response beats, opcodes, status codes and cell commands.
// ----------------------------------------------------------------------------
package pls_pkg;

  typedef enum logic [2:0] {
    PLS_OP_INS_HEAD = 3'd0,
    PLS_OP_INS_TAIL = 3'd1,
    PLS_OP_INS_POS  = 3'd2,
    PLS_OP_DEL_HEAD = 3'd3,
    PLS_OP_DEL_TAIL = 3'd4,
    PLS_OP_DEL_POS  = 3'd5,
    PLS_OP_DISPLAY  = 3'd6,
    PLS_OP_CLEAR    = 3'd7
  } pls_opcode_t;

  typedef enum logic [1:0] {
    PLS_ST_OK     = 2'd0,
    PLS_ST_EMPTY  = 2'd1,
    PLS_ST_BADPOS = 2'd2,
    PLS_ST_FULL   = 2'd3
  } pls_status_t;

  typedef struct packed {
    pls_opcode_t        opcode;
    logic signed [31:0] value;
    logic [4:0]         position;
  } pls_req_t;

  typedef struct packed {
    pls_status_t        status;
    logic signed [31:0] element;
    logic               last;
  } pls_rsp_t;

  // per-cell move for one cycle
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_LEFT,
    CELL_RIGHT,
    CELL_HEAD
  } pls_cell_cmd_t;

  // what the whole chain does this cycle
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_INSERT,
    ACT_REMOVE,
    ACT_ROTATE
  } pls_act_t;

  typedef enum logic {
    PLS_IDLE,
    PLS_DISP
  } pls_state_t;

endpackage

>>> hdl/pls_cell.sv
// ----------------------------------------------------------------------------
// pls_cell: one storage cell of the list chain
// Holds one entry; each cycle it keeps it or takes a neighbor, the new value or the head.
// ----------------------------------------------------------------------------
module pls_cell
  import pls_pkg::*;
(
  input  logic          clk,
  input  pls_cell_cmd_t cmd,
  input  logic [31:0]   left,
  input  logic [31:0]   right,
  input  logic [31:0]   load_value,
  input  logic [31:0]   head,
  output logic [31:0]   q
);

  always_ff @(posedge clk) begin
    case (cmd)
      CELL_LOAD:  q <= load_value;
      CELL_LEFT:  q <= left;
      CELL_RIGHT: q <= right;
      CELL_HEAD:  q <= head;
      default:    q <= q;
    endcase
  end

endmodule

>>> hdl/positional_list_store_core.sv
// ----------------------------------------------------------------------------
// positional_list_store_core: bounded ordered list in a chain of cells
// Insert, delete, display and clear on a list of signed 32-bit entries.
// ----------------------------------------------------------------------------
//  channel | beat type  | handshake            | beats per request
//  req     | pls_req_t  | req_valid/req_ready  | 1
//  rsp     | pls_rsp_t  | rsp_valid/rsp_ready  | 1, or length for a non-empty display
//
//  Insert and delete shift the chain when accepted; clear only resets the
//  length. Display emits length beats, each rotating the chain by one and
//  emitting the head, so the list is back in place after the final beat.
//  req_ready drops during a display and while the response register is full
//  and not being taken. Reset empties the list at once; no clearing pass.
// ----------------------------------------------------------------------------
module positional_list_store_core
  import pls_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  pls_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output pls_rsp_t rsp
);

  localparam int LEN_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = ((LEN_W > 5) ? LEN_W : 5) + 1;

  logic [31:0]         cells [CAPACITY];
  pls_cell_cmd_t       cmd   [CAPACITY];

  pls_state_t          state, state_next;
  logic [LEN_W-1:0]    length, length_next;
  logic [LEN_W-1:0]    cnt, cnt_next;
  logic                rsp_load;
  pls_rsp_t            rsp_next;
  pls_act_t            act;
  logic [IDX_W-1:0]    act_idx;
  logic                slot_free;
  logic                accept;
  logic [CMP_W-1:0]    pos_ext, len_ext;
  logic                full;

  assign slot_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == PLS_IDLE) && slot_free;
  assign accept    = req_valid && req_ready;
  assign pos_ext   = CMP_W'(req.position);
  assign len_ext   = CMP_W'(length);
  assign full      = (length == LEN_W'(CAPACITY));

  always_comb begin
    state_next  = state;
    length_next = length;
    cnt_next    = cnt;
    rsp_load    = 1'b0;
    rsp_next    = '{status: PLS_ST_OK, element: '0, last: 1'b1};
    act         = ACT_NONE;
    act_idx     = '0;
    case (state)
      PLS_IDLE: begin
        if (accept) begin
          rsp_load = 1'b1;
          case (req.opcode)
            PLS_OP_INS_HEAD, PLS_OP_INS_TAIL, PLS_OP_INS_POS: begin
              if (full) begin
                rsp_next.status = PLS_ST_FULL;
              end else if (req.opcode == PLS_OP_INS_HEAD) begin
                act = ACT_INSERT;
              end else if (req.opcode == PLS_OP_INS_TAIL) begin
                act     = ACT_INSERT;
                act_idx = IDX_W'(length);
              end else if (req.position == 5'd0 || pos_ext > len_ext + CMP_W'(1)) begin
                rsp_next.status = PLS_ST_BADPOS;
              end else begin
                act     = ACT_INSERT;
                act_idx = IDX_W'(req.position - 5'd1);
              end
              if (act == ACT_INSERT) begin
                length_next = length + LEN_W'(1);
              end
            end
            PLS_OP_DEL_HEAD, PLS_OP_DEL_TAIL, PLS_OP_DEL_POS: begin
              if (length == '0) begin
                rsp_next.status = PLS_ST_EMPTY;
              end else if (req.opcode == PLS_OP_DEL_HEAD) begin
                act = ACT_REMOVE;
              end else if (req.opcode == PLS_OP_DEL_TAIL) begin
                act     = ACT_REMOVE;
                act_idx = IDX_W'(length - LEN_W'(1));
              end else if (req.position == 5'd0 || pos_ext > len_ext) begin
                rsp_next.status = PLS_ST_BADPOS;
              end else begin
                act     = ACT_REMOVE;
                act_idx = IDX_W'(req.position - 5'd1);
              end
              if (act == ACT_REMOVE) begin
                length_next      = length - LEN_W'(1);
                rsp_next.element = cells[act_idx];
              end
            end
            PLS_OP_DISPLAY: begin
              if (length == '0) begin
                rsp_next.status = PLS_ST_EMPTY;
              end else begin
                act              = ACT_ROTATE;
                rsp_next.element = cells[0];
                rsp_next.last    = (length == LEN_W'(1));
                if (length != LEN_W'(1)) begin
                  state_next = PLS_DISP;
                  cnt_next   = LEN_W'(1);
                end
              end
            end
            default: begin
              // clear
              length_next = '0;
            end
          endcase
        end
      end
      PLS_DISP: begin
        if (slot_free) begin
          rsp_load         = 1'b1;
          act              = ACT_ROTATE;
          rsp_next.element = cells[0];
          rsp_next.last    = (cnt == length - LEN_W'(1));
          cnt_next         = cnt + LEN_W'(1);
          if (rsp_next.last) begin
            state_next = PLS_IDLE;
          end
        end
      end
      default: begin
        state_next = PLS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= PLS_IDLE;
      length    <= '0;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state  <= state_next;
      length <= length_next;
      cnt    <= cnt_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_chain
    logic [31:0] left_in, right_in;

    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cells[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cells[i+1];
    end

    always_comb begin
      cmd[i] = CELL_HOLD;
      case (act)
        ACT_INSERT: begin
          if (IDX_W'(i) == act_idx) begin
            cmd[i] = CELL_LOAD;
          end else if (IDX_W'(i) > act_idx) begin
            cmd[i] = CELL_LEFT;
          end
        end
        ACT_REMOVE: begin
          if (IDX_W'(i) >= act_idx && LEN_W'(i + 1) < length) begin
            cmd[i] = CELL_RIGHT;
          end
        end
        ACT_ROTATE: begin
          // wrap the head around to the last occupied cell
          if (LEN_W'(i + 1) < length) begin
            cmd[i] = CELL_RIGHT;
          end else if (LEN_W'(i + 1) == length) begin
            cmd[i] = CELL_HEAD;
          end
        end
        default: cmd[i] = CELL_HOLD;
      endcase
    end

    pls_cell u_cell (
      .clk        (clk),
      .cmd        (cmd[i]),
      .left       (left_in),
      .right      (right_in),
      .load_value (req.value),
      .head       (cells[0]),
      .q          (cells[i])
    );
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    length <= LEN_W'(CAPACITY))
    else $error("list length above capacity");

  a_disp_len_stable: assert property (@(posedge clk) disable iff (rst)
    (state == PLS_DISP) |=> $stable(length))
    else $error("length changed during display");

  a_disp_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == PLS_DISP) |-> (cnt != '0 && cnt < length))
    else $error("display count out of range");

  a_disp_end: assert property (@(posedge clk) disable iff (rst)
    (state == PLS_DISP && slot_free && cnt == length - LEN_W'(1)) |=>
      (state == PLS_IDLE && rsp_valid && rsp.last))
    else $error("display did not end on its final beat");

endmodule
